// File: rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants of the sector block cache prefetcher.
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int INDEX_BITS_DEF    = 12;
	localparam int BLOCK_SECTORS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int MAX_PREFETCH_DEF  = 16;

	typedef enum logic [1:0] {
		CMD_HOST  = 2'd0,
		CMD_POLL  = 2'd1,
		CMD_DONE  = 2'd2,
		CMD_MEDIA = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ACT_IGNORED = 4'd0,
		ACT_QUEUED  = 4'd1,
		ACT_HIT     = 4'd2,
		ACT_ISSUE   = 4'd3,
		ACT_FILLED  = 4'd4,
		ACT_FAILED  = 4'd5,
		ACT_DROPPED = 4'd6,
		ACT_FLUSHED = 4'd7,
		ACT_IDLE    = 4'd8
	} action_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic align;
		logic lookup;
		logic commit;
		logic clear;
	} ctrl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic in_host;
		logic media_q;
		logic out_stall;
		logic clear_last;
	} ctrl_stat_t;

endpackage

// File: rtl/sector_block_cache_prefetcher_top.sv
// ----------------------------------------------------------------------------
// sector_block_cache_prefetcher_top
// Read-ahead controller for a disc sector cache with a direct-mapped tag
// directory, a request queue and a sequential prefetch run.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid/in_ready   | cmd, sector, read_ok
//  out     | out_valid/out_ready | action, block_address, prefetch_left,
//          |                     | queue_level
//  cfg     | cfg_valid/cfg_ready | cfg_data (sector_count)
//
//  a host request goes through residue stage, align stage, tag read and resolve;
//  poll, read done and media change go through tag read at accept and resolve
//  an item's tag write back happens at resolve, after its tag read
//  after reset and after each media change a sweep over all 2^INDEX_BITS entries
//  (4096 by default) clears the tag valid bits, no item is accepted meanwhile
//  the result sits in an output register; the next item is accepted while it
//  waits, and that item's resolve stalls until the result is taken
// ----------------------------------------------------------------------------
module sector_block_cache_prefetcher_top import sbc_pkg::*; #(
	parameter int INDEX_BITS    = INDEX_BITS_DEF,
	parameter int BLOCK_SECTORS = BLOCK_SECTORS_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
	parameter int MAX_PREFETCH  = MAX_PREFETCH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        cmd,
	input  logic [31:0]                       sector,
	input  logic                              read_ok,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [3:0]                        action,
	output logic [31:0]                       block_address,
	output logic [$clog2(MAX_PREFETCH+1)-1:0] prefetch_left,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]  queue_level,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [31:0]                       cfg_data
);

	ctrl_cmd_t  ctl;
	ctrl_stat_t stat;

	assign cfg_ready = 1'b1;

	sbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	sbc_datapath #(
		.INDEX_BITS    (INDEX_BITS),
		.BLOCK_SECTORS (BLOCK_SECTORS),
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.MAX_PREFETCH  (MAX_PREFETCH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sector        (sector),
		.read_ok       (read_ok),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.block_address (block_address),
		.prefetch_left (prefetch_left),
		.queue_level   (queue_level)
	);

	// a result only ever shows up right after a commit
	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.commit))
		else $error("result without commit");

	// no item taken while the tag sweep runs or a result is being resolved
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.clear || ctl.commit) |-> !in_ready)
		else $error("item accepted while busy");

	// a commit never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !ctl.commit)
		else $error("pending result overwritten");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (queue_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
		else $error("queue level out of range");

	a_prefetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (prefetch_left <= ($clog2(MAX_PREFETCH+1))'(MAX_PREFETCH)))
		else $error("prefetch count out of range");

endmodule

// File: rtl/sbc_ctrl.sv
// ----------------------------------------------------------------------------
// sbc_ctrl
// Sequencer: accept, block alignment, tag lookup, commit and tag clear sweep.
// ----------------------------------------------------------------------------
module sbc_ctrl import sbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  ctl
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ALIGN = 5'b00010,
		S_READ  = 5'b00100,
		S_WRITE = 5'b01000,
		S_CLEAR = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					// host requests need the block alignment first
					state_d = stat.in_host ? S_ALIGN : S_WRITE;
				end
			end
			S_ALIGN: begin
				ctl.align = 1'b1;
				state_d   = S_READ;
			end
			S_READ: begin
				ctl.lookup = 1'b1;
				state_d    = S_WRITE;
			end
			S_WRITE: begin
				if (!stat.out_stall) begin
					ctl.commit = 1'b1;
					state_d    = stat.media_q ? S_CLEAR : S_IDLE;
				end
			end
			S_CLEAR: begin
				ctl.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

// File: rtl/sbc_datapath.sv
// ----------------------------------------------------------------------------
// sbc_datapath
// Tag directory, request queue, prefetch state, alignment and output register.
// ----------------------------------------------------------------------------
module sbc_datapath import sbc_pkg::*; #(
	parameter int INDEX_BITS    = INDEX_BITS_DEF,
	parameter int BLOCK_SECTORS = BLOCK_SECTORS_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
	parameter int MAX_PREFETCH  = MAX_PREFETCH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ctrl_cmd_t                             ctl,
	output ctrl_stat_t                            stat,
	input  logic                                  cfg_we,
	input  logic [31:0]                           cfg_data,
	input  logic [1:0]                            cmd,
	input  logic [31:0]                           sector,
	input  logic                                  read_ok,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [3:0]                            action,
	output logic [31:0]                           block_address,
	output logic [$clog2(MAX_PREFETCH+1)-1:0]     prefetch_left,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]      queue_level
);

	localparam int TAG_N = 1 << INDEX_BITS;
	localparam int QW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int PW    = $clog2(MAX_PREFETCH + 1);
	localparam int L     = $clog2(BLOCK_SECTORS);
	localparam int RW    = L;
	localparam int YW    = 2 * RW;
	localparam int DW    = $clog2(MAX_PREFETCH * BLOCK_SECTORS);

	// reciprocals for exact division by the block size over a known range
	localparam longint unsigned RCP16_L =
		((64'd1 << (16 + L)) + BLOCK_SECTORS - 1) / BLOCK_SECTORS;
	localparam longint unsigned RCPY_L =
		((64'd1 << (YW + L)) + BLOCK_SECTORS - 1) / BLOCK_SECTORS;
	localparam longint unsigned RCPD_L =
		((64'd1 << (DW + L)) + BLOCK_SECTORS - 1) / BLOCK_SECTORS;
	localparam logic [16:0]   RCP16 = 17'(RCP16_L);
	localparam logic [YW:0]   RCPY  = (YW+1)'(RCPY_L);
	localparam logic [DW:0]   RCPD  = (DW+1)'(RCPD_L);
	localparam logic [RW-1:0] K16   = RW'((64'd1 << 16) % BLOCK_SECTORS);
	localparam logic [31:0]   TH    = 32'((MAX_PREFETCH - 1) * BLOCK_SECTORS);

	function automatic logic [INDEX_BITS-1:0] fold(input logic [31:0] b);
		logic [INDEX_BITS-1:0] t;
		t = '0;
		for (int s = 0; s < 32; s += INDEX_BITS) begin
			t = t ^ INDEX_BITS'(b >> s);
		end
		return t;
	endfunction

	// control state
	logic [31:0]     sc_q;
	logic [CW-1:0]   count_q;
	logic [QW-1:0]   head_q;
	logic [31:0]     last_q;
	logic [PW-1:0]   pf_q;
	logic [31:0]     pend_q;
	logic            busy_q;
	logic            req_q;
	logic            out_valid_q;
	logic [INDEX_BITS-1:0] clr_q;

	// payload registers
	logic [31:0]     fifo_q [QUEUE_DEPTH];
	logic [32:0]     tag_mem [TAG_N];
	logic [32:0]     rd_q;
	cmd_t            cmd_q;
	logic [31:0]     sector_q;
	logic            ok_q;
	logic            in_range_q;
	logic [RW-1:0]   rhi_q, rlo_q;
	logic [31:0]     blk_q;
	logic            rs_zero_q, rs_big_q;
	logic [DW-1:0]   rs_d_q;
	action_t         act_q;
	logic [31:0]     addr_q;
	logic [PW-1:0]   pl_q;
	logic [CW-1:0]   ql_q;

	// ---------------- accept cycle: residues, block select, restart prep
	logic [32:0] phi, plo;
	logic [15:0] qhi, qlo;
	logic [RW-1:0] rhi, rlo;

	assign phi = 33'(sector[31:16]) * 33'(RCP16);
	assign plo = 33'(sector[15:0]) * 33'(RCP16);
	assign qhi = 16'(phi >> (16 + L));
	assign qlo = 16'(plo >> (16 + L));
	assign rhi = RW'(sector[31:16] - 16'(qhi * 16'(BLOCK_SECTORS)));
	assign rlo = RW'(sector[15:0] - 16'(qlo * 16'(BLOCK_SECTORS)));

	logic [31:0] sel_blk;
	logic [32:0] nxt;
	logic [31:0] dd;

	always_comb begin
		if (cmd_t'(cmd) == CMD_DONE) begin
			sel_blk = pend_q;
		end else if (count_q != '0) begin
			sel_blk = fifo_q[head_q];
		end else begin
			sel_blk = last_q + 32'(BLOCK_SECTORS);
		end
	end

	assign nxt = {1'b0, sel_blk} + 33'(BLOCK_SECTORS);
	assign dd  = 32'({1'b0, sc_q} - nxt);

	// ---------------- align cycle: combine residues, drop them from the sector
	logic [YW-1:0]   y;
	logic [2*YW:0]   py;
	logic [YW-1:0]   qy;
	logic [RW-1:0]   ry;
	logic [31:0]     blk_align;

	assign y  = YW'(YW'(rhi_q) * YW'(K16)) + YW'(rlo_q);
	assign py = (2*YW+1)'(y) * (2*YW+1)'(RCPY);
	assign qy = YW'(py >> (YW + L));
	assign ry = RW'(y - YW'(qy * YW'(BLOCK_SECTORS)));
	assign blk_align = sector_q - 32'(ry);

	// ---------------- resolve cycle
	logic [DW-1:0]   xd;
	logic [2*DW:0]   pxd;
	logic [PW-1:0]   restart;
	logic            hit;

	assign xd  = rs_d_q + DW'(BLOCK_SECTORS - 1);
	assign pxd = (2*DW+1)'(xd) * (2*DW+1)'(RCPD);
	always_comb begin
		if (rs_zero_q) begin
			restart = '0;
		end else if (rs_big_q) begin
			restart = PW'(MAX_PREFETCH);
		end else begin
			restart = PW'(pxd >> (DW + L));
		end
	end

	assign hit = rd_q[32] && (rd_q[31:0] == blk_q);

	logic [QW:0]   tail_sum;
	logic [QW-1:0] tail;
	logic [QW-1:0] head_inc;

	assign tail_sum = (QW+1)'(head_q) + (QW+1)'(count_q);
	assign tail     = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
		QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
	assign head_inc = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	action_t       act;
	logic [31:0]   addr;
	logic [CW-1:0] count_d;
	logic [QW-1:0] head_d;
	logic [31:0]   last_d;
	logic [PW-1:0] pf_d;
	logic [31:0]   pend_d;
	logic          busy_d, req_d, push, fill;

	always_comb begin
		act     = ACT_IGNORED;
		addr    = '0;
		count_d = count_q;
		head_d  = head_q;
		last_d  = last_q;
		pf_d    = pf_q;
		pend_d  = pend_q;
		busy_d  = busy_q;
		req_d   = req_q;
		push    = 1'b0;
		fill    = 1'b0;
		unique case (cmd_q)
			CMD_HOST: begin
				if (in_range_q) begin
					addr = blk_q;
					if (hit) begin
						act = ACT_HIT;
					end else if (count_q == CW'(QUEUE_DEPTH)) begin
						act = ACT_DROPPED;
					end else begin
						act     = ACT_QUEUED;
						push    = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
			end
			CMD_POLL: begin
				if (!busy_q) begin
					if (count_q == '0 && pf_q == '0) begin
						act = ACT_IDLE;
					end else begin
						// queued request first, else the next prefetch block
						if (count_q != '0) begin
							count_d = count_q - 1'b1;
							head_d  = head_inc;
						end else begin
							pf_d = pf_q - 1'b1;
						end
						addr = blk_q;
						if (hit) begin
							act    = ACT_HIT;
							last_d = blk_q;
							if (count_q != '0) begin
								pf_d = restart;
							end
						end else begin
							act    = ACT_ISSUE;
							pend_d = blk_q;
							busy_d = 1'b1;
							req_d  = (count_q != '0);
						end
					end
				end
			end
			CMD_DONE: begin
				if (busy_q) begin
					addr = pend_q;
					if (ok_q) begin
						act    = ACT_FILLED;
						fill   = 1'b1;
						last_d = pend_q;
						if (req_q) begin
							pf_d = restart;
						end
					end else begin
						act  = ACT_FAILED;
						pf_d = '0;
					end
					busy_d = 1'b0;
					req_d  = 1'b0;
				end
			end
			CMD_MEDIA: begin
				act     = ACT_FLUSHED;
				count_d = '0;
				head_d  = '0;
				pf_d    = '0;
				busy_d  = 1'b0;
				req_d   = 1'b0;
			end
			default: begin
				act = ACT_IGNORED;
			end
		endcase
	end

	// ---------------- tag directory, valid bit stored with the tag
	logic                  mem_we, mem_re;
	logic [INDEX_BITS-1:0] mem_wa, mem_ra;
	logic [32:0]           mem_wd;

	assign mem_we = ctl.clear || (ctl.commit && fill);
	assign mem_wa = ctl.clear ? clr_q : fold(pend_q);
	assign mem_wd = ctl.clear ? 33'd0 : {1'b1, pend_q};
	assign mem_re = ctl.accept || ctl.lookup;
	assign mem_ra = ctl.lookup ? fold(blk_q) : fold(sel_blk);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= tag_mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit && push) begin
			fifo_q[tail] <= blk_q;
		end
	end

	// ---------------- payload registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q      <= cmd_t'(cmd);
			sector_q   <= sector;
			ok_q       <= read_ok;
			in_range_q <= (sector < sc_q);
			rhi_q      <= rhi;
			rlo_q      <= rlo;
			rs_zero_q  <= (nxt >= {1'b0, sc_q});
			rs_big_q   <= (dd > TH);
			rs_d_q     <= DW'(dd);
		end
		if (ctl.align) begin
			blk_q <= blk_align;
		end else if (ctl.accept) begin
			blk_q <= sel_blk;
		end
		if (ctl.commit) begin
			act_q  <= act;
			addr_q <= addr;
			pl_q   <= pf_d;
			ql_q   <= count_d;
		end
	end

	// ---------------- control state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q        <= '0;
			count_q     <= '0;
			head_q      <= '0;
			last_q      <= '0;
			pf_q        <= '0;
			pend_q      <= '0;
			busy_q      <= 1'b0;
			req_q       <= 1'b0;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			if (cfg_we) begin
				sc_q <= cfg_data;
			end
			if (ctl.commit) begin
				count_q <= count_d;
				head_q  <= head_d;
				last_q  <= last_d;
				pf_q    <= pf_d;
				pend_q  <= pend_d;
				busy_q  <= busy_d;
				req_q   <= req_d;
			end
			if (ctl.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.in_host    = (cmd_t'(cmd) == CMD_HOST);
	assign stat.media_q    = (cmd_q == CMD_MEDIA);
	assign stat.out_stall  = out_valid_q && !out_ready;
	assign stat.clear_last = (clr_q == '1);

	assign out_valid     = out_valid_q;
	assign action        = act_q;
	assign block_address = addr_q;
	assign prefetch_left = pl_q;
	assign queue_level   = ql_q;

endmodule
